// ----- hw/rtl/intfmt_pkg.sv -----
// Shared constants, codes, command and status types for the integer field formatter.
package intfmt_pkg;

  localparam int ValueW      = 64;
  localparam int BaseW       = 5;
  localparam int ConvW       = 3;
  localparam int WidthW      = 6;
  localparam int PrecW       = 7;
  localparam int CharW       = 8;
  localparam int CountW      = 6;
  localparam int MaxDigits   = 32;
  localparam int MaxWidth    = 62;
  localparam int DigW        = 4;
  localparam int NdigW       = $clog2(MaxDigits + 1);
  localparam int DigIdxW     = $clog2(MaxDigits);
  localparam int PosW        = 7;
  localparam int BitsPerStep = 8;
  localparam int StepCount   = ValueW / BitsPerStep;
  localparam int StepW       = $clog2(StepCount);
  localparam int InTdataW    = 88;
  localparam int InTuserW    = ConvW;
  localparam int OutTdataW   = 16;

  localparam logic [ConvW-1:0] CONV_SIGNED   = 3'd0;
  localparam logic [ConvW-1:0] CONV_UNSIGNED = 3'd1;
  localparam logic [ConvW-1:0] CONV_HEX_LO   = 3'd2;
  localparam logic [ConvW-1:0] CONV_HEX_UP   = 3'd3;
  localparam logic [ConvW-1:0] CONV_PTR      = 3'd4;

  localparam logic [BaseW-1:0] BASE_MIN = 5'd8;
  localparam logic [BaseW-1:0] BASE_MAX = 5'd16;

  localparam logic [1:0] PRE_NONE = 2'd0;
  localparam logic [1:0] PRE_SIGN = 2'd1;
  localparam logic [1:0] PRE_HEX  = 2'd2;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CH_UP_X  = 8'h58;
  localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
  localparam logic [CharW-1:0] CH_LO_X  = 8'h78;

  typedef struct packed {
    logic load;
    logic div_step;
    logic digit_done;
    logic plan_a;
    logic plan_b;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic more_digits;
    logic out_free;
    logic emit_last;
  } dp_sts_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d,
                                                   input logic upper);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CharW'(d);
    end else if (upper) begin
      c = CH_UP_A + CharW'(d) - 8'd10;
    end else begin
      c = CH_LO_A + CharW'(d) - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/intfmt_ctrl.sv -----
// Controller state machine that sequences digit generation, layout planning and emission.
module intfmt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  intfmt_pkg::dp_sts_t sts,
  output intfmt_pkg::dp_cmd_t cmd
);
  import intfmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIGIT,
    S_PLAN_A,
    S_PLAN_B,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.digit_done = 1'b1;
        state_nxt      = sts.more_digits ? S_DIV : S_PLAN_A;
      end
      S_PLAN_A: begin
        cmd.plan_a = 1'b1;
        state_nxt  = S_PLAN_B;
      end
      S_PLAN_B: begin
        cmd.plan_b = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DIV))
    else $error("accepted item did not start digit generation");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("character emitted while the output register was full");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.emit_last) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after the last item");

endmodule

// ----- hw/rtl/intfmt_dp.sv -----
// Datapath: input capture, digit-serial divider, digit store, layout planner and output register.
module intfmt_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [intfmt_pkg::InTdataW-1:0]   in_tdata,
  input  logic [intfmt_pkg::InTuserW-1:0]   in_tuser,
  input  intfmt_pkg::dp_cmd_t               cmd,
  output intfmt_pkg::dp_sts_t               sts,
  input  logic                              out_tready,
  output logic                              out_valid,
  output logic [intfmt_pkg::CharW-1:0]      out_char,
  output logic                              out_has,
  output logic                              out_last,
  output logic [intfmt_pkg::CountW-1:0]     out_count
);
  import intfmt_pkg::*;

  logic [ValueW-1:0] in_value;
  logic [BaseW-1:0]  in_base;
  logic [ConvW-1:0]  in_conv;

  logic [ValueW-1:0] dvd_r;
  logic [DigW-1:0]   rem_r;
  logic [StepW-1:0]  step_r;
  logic [NdigW-1:0]  ndig_r;
  logic [DigW-1:0]   digs_r [MaxDigits];
  logic              val_zero_r;
  logic [BaseW-1:0]  base_r;
  logic [ConvW-1:0]  conv_r;
  logic              neg_r;
  logic              plus_r;
  logic              space_r;
  logic              hash_r;
  logic              zero_r;
  logic              left_r;
  logic [WidthW-1:0] width_r;
  logic [PrecW-1:0]  prec_r;

  logic [NdigW-1:0]  nd_r;
  logic [WidthW-1:0] zeros_r;
  logic [1:0]        pre_r;
  logic [PosW-1:0]   content_r;
  logic [PosW-1:0]   b1_r;
  logic [PosW-1:0]   b2_r;
  logic [PosW-1:0]   b3_r;
  logic [PosW-1:0]   b4_r;
  logic [CountW-1:0] cnt_r;
  logic [PosW-1:0]   pos_r;

  logic              out_valid_r;
  logic [CharW-1:0]  out_char_r;
  logic              out_has_r;
  logic              out_last_r;
  logic [CountW-1:0] out_count_r;

  logic [ValueW-1:0] dvd_nxt;
  logic [DigW-1:0]   rem_nxt;
  logic [DigW:0]     acc;

  logic [NdigW-1:0]  nd_eff;
  logic [WidthW-1:0] zeros_nxt;
  logic [1:0]        pre_nxt;
  logic [WidthW-1:0] pad;
  logic              use_fill;
  logic [PosW-1:0]   spaces;
  logic [PosW-1:0]   zrun;
  logic [PosW-1:0]   b1_nxt;
  logic [PosW-1:0]   b2_nxt;
  logic [PosW-1:0]   b3_nxt;
  logic [PosW-1:0]   b4_nxt;
  logic [PosW-1:0]   total;

  logic [PosW-1:0]   dig_idx;
  logic [CharW-1:0]  sign_char;
  logic [CharW-1:0]  char_nxt;

  assign in_value = in_tdata[63:0];
  assign in_base  = in_tdata[68:64];
  assign in_conv  = in_tuser;

  // One chunk of restoring division by the base; the dividend register turns into the quotient.
  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    acc     = '0;
    for (int i = 0; i < BitsPerStep; i++) begin
      acc     = {rem_nxt, dvd_nxt[ValueW-1]};
      dvd_nxt = {dvd_nxt[ValueW-2:0], 1'b0};
      if (acc >= base_r) begin
        acc        = acc - base_r;
        dvd_nxt[0] = 1'b1;
      end
      rem_nxt = acc[DigW-1:0];
    end
  end

  always_comb begin
    nd_eff    = (val_zero_r && prec_r == '0) ? '0 : ndig_r;
    zeros_nxt = '0;
    if (!prec_r[PrecW-1] && prec_r[WidthW-1:0] > WidthW'(nd_eff)) begin
      zeros_nxt = prec_r[WidthW-1:0] - WidthW'(nd_eff);
    end
    if (neg_r || (conv_r == CONV_SIGNED && (plus_r || space_r))) begin
      pre_nxt = PRE_SIGN;
    end else if (conv_r == CONV_PTR ||
                 (hash_r && !val_zero_r &&
                  (conv_r == CONV_HEX_LO || conv_r == CONV_HEX_UP))) begin
      pre_nxt = PRE_HEX;
    end else begin
      pre_nxt = PRE_NONE;
    end
  end

  always_comb begin
    pad      = ({1'b0, width_r} > content_r) ? WidthW'({1'b0, width_r} - content_r) : '0;
    use_fill = zero_r && !left_r && prec_r[PrecW-1];
    spaces   = use_fill ? '0 : PosW'(pad);
    zrun     = PosW'(zeros_r) + (use_fill ? PosW'(pad) : '0);
    b1_nxt   = left_r ? '0 : spaces;
    b2_nxt   = b1_nxt + PosW'(pre_r);
    b3_nxt   = b2_nxt + zrun;
    b4_nxt   = b3_nxt + PosW'(nd_r);
    total    = b4_nxt + (left_r ? spaces : '0);
  end

  always_comb begin
    dig_idx   = b4_r - 7'd1 - pos_r;
    sign_char = neg_r ? CH_MINUS : (plus_r ? CH_PLUS : CH_SPACE);
    if (pos_r < b1_r) begin
      char_nxt = CH_SPACE;
    end else if (pos_r < b2_r) begin
      if (pre_r == PRE_SIGN) begin
        char_nxt = sign_char;
      end else if (pos_r == b1_r) begin
        char_nxt = CH_ZERO;
      end else begin
        char_nxt = (conv_r == CONV_HEX_UP) ? CH_UP_X : CH_LO_X;
      end
    end else if (pos_r < b3_r) begin
      char_nxt = CH_ZERO;
    end else if (pos_r < b4_r) begin
      char_nxt = digit_char(digs_r[dig_idx[DigIdxW-1:0]], conv_r == CONV_HEX_UP);
    end else begin
      char_nxt = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd_r      <= in_value;
      rem_r      <= '0;
      step_r     <= '0;
      ndig_r     <= '0;
      val_zero_r <= (in_value == '0);
      base_r     <= (in_base < BASE_MIN) ? BASE_MIN :
                    ((in_base > BASE_MAX) ? BASE_MAX : in_base);
      conv_r     <= (in_conv > CONV_PTR) ? CONV_UNSIGNED : in_conv;
      neg_r      <= in_tdata[69];
      plus_r     <= in_tdata[70];
      space_r    <= in_tdata[71];
      hash_r     <= in_tdata[72];
      zero_r     <= in_tdata[73];
      left_r     <= in_tdata[74];
      width_r    <= in_tdata[80:75];
      prec_r     <= in_tdata[87:81];
    end
    if (cmd.div_step) begin
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + 3'd1;
    end
    if (cmd.digit_done) begin
      digs_r[ndig_r[DigIdxW-1:0]] <= rem_r;
      ndig_r <= ndig_r + 6'd1;
      rem_r  <= '0;
      step_r <= '0;
    end
    if (cmd.plan_a) begin
      nd_r      <= nd_eff;
      zeros_r   <= zeros_nxt;
      pre_r     <= pre_nxt;
      content_r <= PosW'(pre_nxt) + PosW'(nd_eff) + PosW'(zeros_nxt);
    end
    if (cmd.plan_b) begin
      b1_r  <= b1_nxt;
      b2_r  <= b2_nxt;
      b3_r  <= b3_nxt;
      b4_r  <= b4_nxt;
      cnt_r <= (total > PosW'(MaxWidth)) ? CountW'(MaxWidth) : total[CountW-1:0];
      pos_r <= '0;
    end
    if (cmd.emit) begin
      pos_r       <= pos_r + 7'd1;
      out_char_r  <= (cnt_r == '0) ? CH_NUL : char_nxt;
      out_has_r   <= (cnt_r != '0);
      out_last_r  <= sts.emit_last;
      out_count_r <= sts.emit_last ? cnt_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.div_last    = (step_r == StepW'(StepCount - 1));
  assign sts.more_digits = (dvd_r != '0) && (ndig_r < NdigW'(MaxDigits - 1));
  assign sts.out_free    = !out_valid_r || out_tready;
  assign sts.emit_last   = (cnt_r == '0) || ((pos_r + 7'd1) == PosW'(cnt_r));

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_has   = out_has_r;
  assign out_last  = out_last_r;
  assign out_count = out_count_r;

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> ({1'b0, rem_r} < base_r))
    else $error("division remainder not below the base");

  a_plan_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.plan_b |=> (b1_r <= b2_r && b2_r <= b3_r && b3_r <= b4_r &&
                    cnt_r <= CountW'(MaxWidth)))
    else $error("character layout boundaries out of order");

  a_last_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.emit_last) |=> (out_valid_r && out_last_r &&
                                     out_count_r == cnt_r))
    else $error("final item lacks last flag or total count");

endmodule

// ----- hw/rtl/integer_field_formatter.sv -----
// Top level of the integer field formatter: controller plus datapath behind stream ports.
//
// Each input item carries one unsigned 64-bit magnitude with its base, conversion kind
// and printf flags. The block answers with one output item per formatted character:
// leading spaces, sign or 0x/0X prefix, zero padding, digits, trailing spaces. The
// final item of a conversion has tlast set and carries the character count; when a
// conversion prints nothing, a single item with tuser low and tlast high is sent.
// Output is capped at 62 characters.
// Digits come from a shared divider that retires 8 dividend bits per cycle; each
// remainder is stored as the next digit. The divider yields 1 to 22 digits per
// conversion, and a conversion gives 1 to 62 output items. One item is in work at a
// time and in_tready is high only while the block is idle, so the next item is
// accepted only after the last character of the previous one has been registered.
// Characters leave through an output register at one per cycle; when the receiver
// holds out_tready low, emission pauses and the pending item stays on the port.
// Reset clears the controller and the output valid flag; no other setup is needed.
module integer_field_formatter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // value[63:0], base[68:64], negative[69], plus_flag[70], space_flag[71],
  // hash_flag[72], zero_flag[73], left_align[74], field_width[80:75], precision[87:81]
  input  logic [intfmt_pkg::InTdataW-1:0]     in_tdata,
  // conv[2:0]
  input  logic [intfmt_pkg::InTuserW-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_char[7:0], total_count[13:8], zero[15:14]
  output logic [intfmt_pkg::OutTdataW-1:0]    out_tdata,
  // has_char[0]
  output logic                                out_tuser,
  output logic                                out_tlast
);
  import intfmt_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [CharW-1:0]  out_char;
  logic [CountW-1:0] out_count;

  intfmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  intfmt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_char   (out_char),
    .out_has    (out_tuser),
    .out_last   (out_tlast),
    .out_count  (out_count)
  );

  assign out_tdata = {(OutTdataW - CharW - CountW)'(0), out_count, out_char};

endmodule

// ----- bench/integer_field_formatter_checker.sv -----
// Checker for the integer field formatter: predicts the character stream and compares it.
module integer_field_formatter_checker
  import intfmt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [InTdataW-1:0]  in_tdata,
  input  logic [InTuserW-1:0]  in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OutTdataW-1:0] out_tdata,
  input  logic                 out_tuser,
  input  logic                 out_tlast,
  output int                   fail_count,
  output int                   pending_chars,
  output int                   chars_checked
);

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic [CountW-1:0] count;
    logic              has_char;
    logic              last;
  } fmt_char_t;

  fmt_char_t expected_chars[$];

  function automatic void format_request(input logic [InTdataW-1:0] td,
                                         input logic [InTuserW-1:0] tu);
    logic [ValueW-1:0] value;
    logic [ValueW-1:0] rest;
    logic [DigW-1:0]   d;
    logic [CharW-1:0]  digits[MaxDigits];
    logic [CharW-1:0]  text[$];
    logic [1:0]        pre;
    logic              neg, plus, space, hash, zero, left, upper;
    int                base, conv, width, prec;
    int                ndig, zeros, fill, spaces, content, n;
    fmt_char_t         e;
    value = td[63:0];
    base  = int'(td[68:64]);
    neg   = td[69];
    plus  = td[70];
    space = td[71];
    hash  = td[72];
    zero  = td[73];
    left  = td[74];
    width = int'(td[80:75]);
    prec  = int'($signed(td[87:81]));
    conv  = int'(tu);
    upper = (tu == CONV_HEX_UP);
    if (base < int'(BASE_MIN)) base = int'(BASE_MIN);
    if (base > int'(BASE_MAX)) base = int'(BASE_MAX);
    if (conv > int'(CONV_PTR)) conv = int'(CONV_UNSIGNED);

    rest = value;
    ndig = 0;
    do begin
      d = DigW'(rest % 64'(base));
      digits[ndig] = (d < 4'd10) ? CH_ZERO + CharW'(d)
                                 : (upper ? CH_UP_A : CH_LO_A) + CharW'(d) - 8'd10;
      ndig++;
      rest = rest / 64'(base);
    end while (rest != 0 && ndig < MaxDigits);
    if (value == 0 && prec == 0) ndig = 0;
    zeros = (prec > ndig) ? prec - ndig : 0;

    if (neg || (conv == int'(CONV_SIGNED) && (plus || space))) begin
      pre = PRE_SIGN;
    end else if (conv == int'(CONV_PTR) ||
                 (hash && value != 0 &&
                  (conv == int'(CONV_HEX_LO) || conv == int'(CONV_HEX_UP)))) begin
      pre = PRE_HEX;
    end else begin
      pre = PRE_NONE;
    end

    content = int'(pre) + ndig + zeros;
    fill = 0;
    spaces = 0;
    if (width > content) begin
      if (zero && !left && prec < 0) fill = width - content;
      else spaces = width - content;
    end

    if (!left) for (int k = 0; k < spaces; k++) text.push_back(CH_SPACE);
    if (pre == PRE_SIGN) begin
      text.push_back(neg ? CH_MINUS : (plus ? CH_PLUS : CH_SPACE));
    end else if (pre == PRE_HEX) begin
      text.push_back(CH_ZERO);
      text.push_back(conv == int'(CONV_HEX_UP) ? CH_UP_X : CH_LO_X);
    end
    for (int k = 0; k < zeros + fill; k++) text.push_back(CH_ZERO);
    for (int k = ndig; k > 0; k--) text.push_back(digits[k - 1]);
    if (left) for (int k = 0; k < spaces; k++) text.push_back(CH_SPACE);

    // Output beyond the width cap is dropped and the count saturates.
    n = (text.size() > MaxWidth) ? MaxWidth : text.size();
    if (n == 0) begin
      e = '{ch: CH_NUL, count: '0, has_char: 1'b0, last: 1'b1};
      expected_chars.push_back(e);
    end
    for (int k = 0; k < n; k++) begin
      e.ch       = text[k];
      e.has_char = 1'b1;
      e.last     = (k == n - 1);
      e.count    = (k == n - 1) ? CountW'(n) : '0;
      expected_chars.push_back(e);
    end
  endfunction

  always @(posedge clk) begin : watch
    fmt_char_t e;
    if (!rst_n) begin
      expected_chars.delete();
      fail_count    <= 0;
      pending_chars <= 0;
      chars_checked <= 0;
    end else begin
      if (in_tvalid && in_tready) format_request(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected output item char %h count %0d has_char %b last %b",
                   $time, out_tdata[7:0], out_tdata[13:8], out_tuser, out_tlast);
        end else begin
          e = expected_chars.pop_front();
          chars_checked <= chars_checked + 1;
          if (out_tdata[7:0] !== e.ch || out_tdata[13:8] !== e.count ||
              out_tdata[15:14] !== 2'b00 || out_tuser !== e.has_char ||
              out_tlast !== e.last) begin
            fail_count <= fail_count + 1;
            $display("%0t: mismatch: expected char %h count %0d pad 0 has_char %b last %b",
                     $time, e.ch, e.count, e.has_char, e.last);
            $display("%0t:           got char %h count %0d pad %0d has_char %b last %b",
                     $time, out_tdata[7:0], out_tdata[13:8], out_tdata[15:14],
                     out_tuser, out_tlast);
          end
        end
      end
      pending_chars <= expected_chars.size();
    end
  end

endmodule

// ----- bench/integer_field_formatter_tb.sv -----
// Testbench top for the integer field formatter: reset, stimulus, flow control and verdict.
module integer_field_formatter_tb;
  import intfmt_pkg::*;

  localparam logic [5:0] FL_NEG   = 6'b000001;
  localparam logic [5:0] FL_PLUS  = 6'b000010;
  localparam logic [5:0] FL_SPACE = 6'b000100;
  localparam logic [5:0] FL_HASH  = 6'b001000;
  localparam logic [5:0] FL_ZERO  = 6'b010000;
  localparam logic [5:0] FL_LEFT  = 6'b100000;
  localparam logic [5:0] FL_NONE  = 6'b000000;

  localparam logic [PrecW-1:0] NO_PREC  = 7'h7f;
  localparam logic [PrecW-1:0] PREC_MIN = 7'h40;
  localparam logic [PrecW-1:0] PREC_MAX = 7'h3f;

  localparam logic [ConvW-1:0] CONV_UNKNOWN_LO = 3'd5;
  localparam logic [ConvW-1:0] CONV_UNKNOWN_HI = 3'd7;
  localparam logic [BaseW-1:0] BASE_DEC        = 5'd10;

  localparam int DirectedCount = 25;
  localparam int RandomCount   = 435;

  typedef struct packed {
    logic [PrecW-1:0]  precision;
    logic [WidthW-1:0] field_width;
    logic [5:0]        flags;
    logic [BaseW-1:0]  base;
    logic [ValueW-1:0] value;
  } fmt_req_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata;
  logic [InTuserW-1:0]  in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OutTdataW-1:0] out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  int                   fail_count;
  int                   pending_chars;
  int                   chars_checked;
  int                   requests_sent;
  bit                   quiet;

  integer_field_formatter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  integer_field_formatter_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_chars (pending_chars),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int idle_cycles();
    return quiet ? 0 : int'($urandom_range(0, 12));
  endfunction

  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ValueW'($urandom_range(0, 255));
      2, 3:    return r;
      4, 5:    return r >> $urandom_range(1, 63);
      6:       return 64'd1 << $urandom_range(0, 63);
      default: return '1;
    endcase
  endfunction

  task automatic send_request(input logic [ValueW-1:0] value, input logic [BaseW-1:0] base,
                              input logic [ConvW-1:0] conv, input logic [5:0] flags,
                              input logic [WidthW-1:0] width,
                              input logic [PrecW-1:0] prec);
    fmt_req_t req;
    int       gap;
    req = {prec, width, flags, base, value};
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= req;
    in_tuser  <= conv;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic send_random_request();
    logic [ConvW-1:0]  conv;
    logic [BaseW-1:0]  base;
    logic [WidthW-1:0] width;
    logic [PrecW-1:0]  prec;
    if ($urandom_range(0, 99) < 75) begin
      conv = ConvW'($urandom_range(CONV_SIGNED, CONV_PTR));
      if ($urandom_range(0, 4) == 0) base = BASE_MIN;
      else if (conv == CONV_HEX_LO || conv == CONV_HEX_UP || conv == CONV_PTR) base = BASE_MAX;
      else base = BASE_DEC;
      width = ($urandom_range(0, 9) == 0) ? WidthW'($urandom_range(0, 63))
                                          : WidthW'($urandom_range(0, 24));
      case ($urandom_range(0, 4))
        0, 1:    prec = NO_PREC;
        2:       prec = '0;
        3:       prec = PrecW'($urandom_range(1, 24));
        default: prec = PrecW'($urandom_range(0, 127));
      endcase
    end else begin
      conv  = ConvW'($urandom_range(0, 7));
      base  = BaseW'($urandom_range(0, 31));
      width = WidthW'($urandom_range(0, 63));
      prec  = PrecW'($urandom_range(0, 127));
    end
    send_request(random_value(), base, conv, 6'($urandom_range(0, 63)), width, prec);
  endtask

  initial begin
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    quiet         = 1'b0;
    requests_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request('0, BASE_DEC, CONV_SIGNED, FL_NONE, 6'd0, 7'd0);
    send_request('0, BASE_DEC, CONV_SIGNED, FL_NONE, 6'd5, 7'd0);
    send_request('0, BASE_DEC, CONV_SIGNED, FL_PLUS, 6'd0, 7'd0);
    send_request('0, BASE_MAX, CONV_PTR, FL_NONE, 6'd0, 7'd0);
    send_request('1, BASE_MIN, CONV_UNSIGNED, FL_NONE, 6'd0, NO_PREC);
    send_request('1, BASE_MAX, CONV_HEX_UP, FL_HASH, 6'd0, NO_PREC);
    send_request(64'hff, BASE_MAX, CONV_HEX_LO, FL_HASH | FL_ZERO, 6'd10, NO_PREC);
    send_request(64'd42, BASE_DEC, CONV_SIGNED, FL_NEG | FL_ZERO, 6'd8, NO_PREC);
    send_request(64'd7, BASE_DEC, CONV_SIGNED, FL_PLUS | FL_LEFT, 6'd5, NO_PREC);
    send_request(64'd7, BASE_DEC, CONV_SIGNED, FL_SPACE, 6'd0, NO_PREC);
    send_request(64'd5, BASE_DEC, CONV_SIGNED, FL_PLUS | FL_SPACE, 6'd0, 7'd3);
    send_request(64'h1234, BASE_MAX, CONV_HEX_LO, FL_NEG | FL_HASH, 6'd0, NO_PREC);
    send_request(64'hbeef, BASE_MAX, CONV_HEX_UP, FL_PLUS | FL_SPACE | FL_HASH, 6'd9,
                 NO_PREC);
    send_request('0, BASE_MAX, CONV_HEX_LO, FL_HASH, 6'd4, NO_PREC);
    send_request(64'd100, 5'd0, CONV_UNSIGNED, FL_NONE, 6'd0, NO_PREC);
    send_request(64'd255, 5'd31, CONV_UNSIGNED, FL_NONE, 6'd0, NO_PREC);
    send_request(64'd12345, BASE_DEC, CONV_UNKNOWN_LO, FL_PLUS, 6'd0, NO_PREC);
    send_request(64'd12345, BASE_DEC, CONV_UNKNOWN_HI, FL_HASH, 6'd0, NO_PREC);
    send_request(64'd12345, BASE_DEC, CONV_SIGNED, FL_ZERO, 6'd12, 7'd8);
    send_request(64'd12345, BASE_DEC, CONV_SIGNED, FL_ZERO | FL_LEFT | FL_PLUS, 6'd12,
                 NO_PREC);
    send_request(64'd9, BASE_DEC, CONV_SIGNED, FL_ZERO, 6'd6, PREC_MIN);
    send_request(64'hdead, BASE_MAX, CONV_PTR, FL_NEG, 6'd0, NO_PREC);
    send_request('0, BASE_MAX, CONV_PTR, FL_ZERO, 6'd20, NO_PREC);
    send_request('1, BASE_DEC, CONV_SIGNED, FL_NEG, 6'd63, PREC_MAX);
    send_request(64'd1, BASE_MAX, CONV_PTR, FL_LEFT, 6'd63, NO_PREC);

    for (int i = 0; i < RandomCount; i++) begin
      if (i % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    in_tvalid <= 1'b0;

    while (pending_chars != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    $display("Formatted %0d requests (%0d directed, the rest random) under random stalls;",
             requests_sent, DirectedCount);
    $display("%0d output characters were compared against the prediction.", chars_checked);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/intfmt_pkg.sv
hw/rtl/intfmt_ctrl.sv
hw/rtl/intfmt_dp.sv
hw/rtl/integer_field_formatter.sv
bench/integer_field_formatter_checker.sv
bench/integer_field_formatter_tb.sv
